[sv/msit_pkg.sv]
// Shared types, codes and sizes of the multi-slot interval timer.
package msit_pkg;

  // Default table size and the cap on reported firings per tick.
  localparam int SLOTS_DEFAULT = 16;
  localparam int MAX_RESULTS   = 16;

  // Command opcodes.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_ADD     = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_DISABLE = 3'd3;
  localparam logic [2:0] OP_ENABLE  = 3'd4;

  // Result status codes.
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_CLASH     = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  // Slot states.
  localparam logic [1:0] SLOT_FREE   = 2'd0;
  localparam logic [1:0] SLOT_ACTIVE = 2'd1;
  localparam logic [1:0] SLOT_PARKED = 2'd2;

  // One slot record as held in the slot RAM.
  typedef struct packed {
    logic [15:0] ident;
    logic [31:0] interval;
    logic [15:0] remaining;
    logic [63:0] last_fire;
  } slot_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_ok;
    logic stop;
    logic last_slot;
    logic out_free;
  } dp_sts_t;

endpackage

[sv/msit_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module msit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/msit_ctrl.sv]
// Controller state machine that sequences the slot walk and the final result.
module msit_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  msit_pkg::dp_sts_t    sts,
  output msit_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.step_ok && (sts.stop || sts.last_slot)) state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command decode; a new word is taken only while idle.
  assign cmd_stall  = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && cmd_valid;
  assign cmd.walk   = (state == S_WALK);
  assign cmd.finish = (state == S_DONE);

endmodule

[sv/msit_dp.sv]
// Datapath: slot state flops, slot RAM, per-slot evaluation and the output register.
module msit_dp #(
  parameter int SLOTS = msit_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  msit_pkg::ctrl_cmd_t cmd,
  output msit_pkg::dp_sts_t   sts,
  input  logic [2:0]          opcode,
  input  logic [15:0]         timer_id,
  input  logic [31:0]         interval_ms,
  input  logic signed [15:0]  repeat_count,
  input  logic [63:0]         now_ms,
  input  logic                rsp_stall,
  output logic                rsp_valid,
  output logic [1:0]          status,
  output logic                fired,
  output logic [15:0]         fired_id,
  output logic                last_result
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(msit_pkg::MAX_RESULTS + 1);
  localparam int WORD_W = $bits(msit_pkg::slot_word_t);

  // Latched command word.
  logic [2:0]  op_q;
  logic [15:0] id_q;
  logic [31:0] ivl_q;
  logic [15:0] cnt_q;
  logic [63:0] now_q;

  // Walk and bookkeeping state.
  logic [1:0]       slot_st [SLOTS];
  logic [IDX_W-1:0] ev_idx;
  logic [IDX_W-1:0] ev_idx_next;
  logic             pend_valid;
  logic [15:0]      pend_id;
  logic [CNT_W-1:0] n_rep;
  logic             clash;
  logic             found;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // RAM ports.
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  msit_pkg::slot_word_t ram_wword;
  logic [WORD_W-1:0]    ram_rdata;
  msit_pkg::slot_word_t rd;

  // Evaluation signals.
  logic [1:0]  cur_st;
  logic        is_tick;
  logic        is_add;
  logic        st_active;
  logic        st_parked;
  logic        ident_hit;
  logic [64:0] due_sum;
  logic        rem_zero;
  logic        due;
  logic        report;
  logic        need_push;
  logic        out_free;
  logic        step_ok;
  logic        stop;
  logic        step;
  logic        fin;
  logic        push_pend;
  logic        add_ok;
  logic [15:0] rem_dec;
  logic [1:0]  res_code;

  msit_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wword),
    .raddr (ev_idx_next),
    .rdata (ram_rdata)
  );

  assign rd = msit_pkg::slot_word_t'(ram_rdata);

  // Capture the accepted word.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= opcode;
      id_q  <= timer_id;
      ivl_q <= interval_ms;
      cnt_q <= repeat_count;
      now_q <= now_ms;
    end
  end

  // Decode of the slot under evaluation. The RAM data always belongs to ev_idx.
  assign cur_st    = slot_st[ev_idx];
  assign is_tick   = (op_q == msit_pkg::OP_TICK);
  assign is_add    = (op_q == msit_pkg::OP_ADD);
  assign st_active = (cur_st == msit_pkg::SLOT_ACTIVE);
  assign st_parked = (cur_st == msit_pkg::SLOT_PARKED);
  assign ident_hit = (rd.ident == id_q);

  // Expiry check: now > last + interval, computed one bit wider so it cannot wrap.
  assign due_sum   = {1'b0, rd.last_fire} + {33'd0, rd.interval};
  assign rem_zero  = (rd.remaining == 16'd0);
  assign due       = st_active && !rem_zero && ({1'b0, now_q} > due_sum);
  assign report    = due && (n_rep < CNT_W'(msit_pkg::MAX_RESULTS));
  assign need_push = report && pend_valid;
  assign rem_dec   = rd.remaining - 16'd1;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign step_ok   = is_tick ? (!need_push || out_free) : 1'b1;

  // A lookup or an add ends at its first hit; a tick never ends early; an unknown opcode ends at once.
  always_comb begin
    unique case (op_q)
      msit_pkg::OP_TICK:    stop = 1'b0;
      msit_pkg::OP_ADD:     stop = st_active && ident_hit;
      msit_pkg::OP_DELETE:  stop = st_active && ident_hit;
      msit_pkg::OP_DISABLE: stop = st_active && ident_hit;
      msit_pkg::OP_ENABLE:  stop = st_parked && ident_hit;
      default:              stop = 1'b1;
    endcase
  end

  assign step      = cmd.walk && step_ok;
  assign fin       = cmd.finish && out_free;
  assign push_pend = step && is_tick && need_push;
  assign add_ok    = is_add && !clash && free_found;

  assign sts.step_ok   = step_ok;
  assign sts.stop      = stop;
  assign sts.last_slot = (ev_idx == IDX_W'(SLOTS - 1));
  assign sts.out_free  = out_free;

  // Walk pointer; it returns to slot zero when the walk ends.
  always_comb begin
    ev_idx_next = ev_idx;
    if (step) begin
      if (sts.last_slot || stop) begin
        ev_idx_next = '0;
      end else begin
        ev_idx_next = ev_idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_idx <= '0;
    end else begin
      ev_idx <= ev_idx_next;
    end
  end

  // RAM write: a firing slot on tick, or the new slot on a successful add.
  always_comb begin
    ram_we    = (step && is_tick && due) || (fin && add_ok);
    ram_waddr = is_tick ? ev_idx : free_idx;
    if (is_tick) begin
      ram_wword.ident     = rd.ident;
      ram_wword.interval  = rd.interval;
      ram_wword.remaining = rd.remaining[15] ? rd.remaining : rem_dec;
      ram_wword.last_fire = now_q;
    end else begin
      ram_wword.ident     = id_q;
      ram_wword.interval  = ivl_q;
      ram_wword.remaining = cnt_q;
      ram_wword.last_fire = 64'd0;
    end
  end

  // Slot state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_st[i] <= msit_pkg::SLOT_FREE;
      end
    end else if (step) begin
      unique case (op_q)
        msit_pkg::OP_TICK: begin
          if (st_active && rem_zero) begin
            slot_st[ev_idx] <= msit_pkg::SLOT_FREE;
          end else if (due && !rd.remaining[15] && (rd.remaining == 16'd1)) begin
            slot_st[ev_idx] <= msit_pkg::SLOT_FREE;
          end
        end
        msit_pkg::OP_DELETE: begin
          if (stop) slot_st[ev_idx] <= msit_pkg::SLOT_FREE;
        end
        msit_pkg::OP_DISABLE: begin
          if (stop) slot_st[ev_idx] <= msit_pkg::SLOT_PARKED;
        end
        msit_pkg::OP_ENABLE: begin
          if (stop) slot_st[ev_idx] <= msit_pkg::SLOT_ACTIVE;
        end
        default: ;
      endcase
    end else if (fin && add_ok) begin
      slot_st[free_idx] <= msit_pkg::SLOT_ACTIVE;
    end
  end

  // Walk bookkeeping: pending firing, report count, lookup outcome.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      n_rep      <= '0;
      clash      <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
      n_rep      <= '0;
      clash      <= 1'b0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (step) begin
      if (is_tick && report) begin
        pend_valid <= 1'b1;
        n_rep      <= n_rep + CNT_W'(1);
      end
      if (is_add && st_active && ident_hit) begin
        clash <= 1'b1;
      end
      if (is_add && (cur_st == msit_pkg::SLOT_FREE) && !free_found) begin
        free_found <= 1'b1;
      end
      if (!is_tick && !is_add && stop) begin
        found <= 1'b1;
      end
    end
  end

  // Payload side of the bookkeeping.
  always_ff @(posedge clk) begin
    if (step && is_tick && report) begin
      pend_id <= rd.ident;
    end
    if (step && is_add && (cur_st == msit_pkg::SLOT_FREE) && !free_found) begin
      free_idx <= ev_idx;
    end
  end

  // Status code of a command word.
  always_comb begin
    unique case (op_q)
      msit_pkg::OP_ADD: begin
        if (clash)           res_code = msit_pkg::STS_CLASH;
        else if (free_found) res_code = msit_pkg::STS_OK;
        else                 res_code = msit_pkg::STS_FULL;
      end
      msit_pkg::OP_DELETE,
      msit_pkg::OP_DISABLE,
      msit_pkg::OP_ENABLE: begin
        res_code = found ? msit_pkg::STS_OK : msit_pkg::STS_NOT_FOUND;
      end
      default: res_code = msit_pkg::STS_OK;
    endcase
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push_pend || fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload; a firing waits for the next so the final one can be marked.
  always_ff @(posedge clk) begin
    if (push_pend) begin
      status      <= msit_pkg::STS_OK;
      fired       <= 1'b1;
      fired_id    <= pend_id;
      last_result <= 1'b0;
    end else if (fin) begin
      last_result <= 1'b1;
      if (is_tick) begin
        status   <= msit_pkg::STS_OK;
        fired    <= pend_valid;
        fired_id <= pend_valid ? pend_id : 16'd0;
      end else begin
        status   <= res_code;
        fired    <= 1'b0;
        fired_id <= 16'd0;
      end
    end
  end

endmodule

[sv/multi_slot_interval_timer.sv]
// Top level of the multi-slot interval timer: controller plus datapath.
// Every word walks the slot table one slot per cycle through the slot RAM read port,
// save while a tick waits on a stalled output; a tick walks every slot before its final result.
// A lookup or add can end before the last slot; a lookup ends at its first matching slot.
// The next word is taken only after the final result of the previous one.
// Reset marks every slot free at once; slot RAM contents are not cleared and need no sweep.
module multi_slot_interval_timer #(
  parameter int SLOTS = msit_pkg::SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [2:0]         opcode,
  input  logic [15:0]        timer_id,
  input  logic [31:0]        interval_ms,
  input  logic signed [15:0] repeat_count,
  input  logic [63:0]        now_ms,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic               fired,
  output logic [15:0]        fired_id,
  output logic               last_result
);

  msit_pkg::ctrl_cmd_t cmd;
  msit_pkg::dp_sts_t   sts;

  msit_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  msit_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .timer_id     (timer_id),
    .interval_ms  (interval_ms),
    .repeat_count (repeat_count),
    .now_ms       (now_ms),
    .rsp_stall    (rsp_stall),
    .rsp_valid    (rsp_valid),
    .status       (status),
    .fired        (fired),
    .fired_id     (fired_id),
    .last_result  (last_result)
  );

endmodule

[sv/msit_checker.sv]
// Port-level checker for the multi-slot interval timer and its bind.
module msit_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic [2:0]         opcode,
  input logic [15:0]        timer_id,
  input logic [31:0]        interval_ms,
  input logic signed [15:0] repeat_count,
  input logic [63:0]        now_ms,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [1:0]         status,
  input logic               fired,
  input logic [15:0]        fired_id,
  input logic               last_result
);

  // A result without a firing is always the final one of its word.
  a_nofire_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !fired) |-> last_result)
    else $error("non-firing result not marked final");

  // A firing always reports ok status.
  a_fire_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && fired) |-> (status == msit_pkg::STS_OK))
    else $error("firing result with error status");

  // The block is busy right after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("word taken while previous word still in work");

  // A stalled command word stays offered with all of its fields unchanged.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_stall) |=> (cmd_valid &&
      $stable({opcode, timer_id, interval_ms, repeat_count, now_ms})))
    else $error("stalled command word changed");

  // A stalled result holds its identifier.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(fired_id)))
    else $error("stalled result changed");

endmodule

bind multi_slot_interval_timer msit_checker u_msit_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd_valid),
  .cmd_stall    (cmd_stall),
  .opcode       (opcode),
  .timer_id     (timer_id),
  .interval_ms  (interval_ms),
  .repeat_count (repeat_count),
  .now_ms       (now_ms),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .status       (status),
  .fired        (fired),
  .fired_id     (fired_id),
  .last_result  (last_result)
);
